FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ddt_pkg.sv
// shared types and constants for the dual down-counter timer
// no dependencies
package ddt_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned OFF_W  = 3;
  localparam int unsigned DATA_W = 32;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  // register word offsets
  localparam logic [OFF_W-1:0] OFF_CTRL    = 3'd0;
  localparam logic [OFF_W-1:0] OFF_STATUS  = 3'd1;
  localparam logic [OFF_W-1:0] OFF_RELOAD0 = 3'd4;
  localparam logic [OFF_W-1:0] OFF_VALUE0  = 3'd5;
  localparam logic [OFF_W-1:0] OFF_RELOAD1 = 3'd6;
  localparam logic [OFF_W-1:0] OFF_VALUE1  = 3'd7;

  // control word bit positions
  localparam int unsigned CTRL_EN0      = 0;
  localparam int unsigned CTRL_RLD0     = 1;
  localparam int unsigned CTRL_EN1      = 2;
  localparam int unsigned CTRL_RLD1     = 3;
  localparam int unsigned CTRL_REF0     = 11;
  localparam int unsigned CTRL_REF1     = 12;
  localparam int unsigned CTRL_DIV0_LSB = 19;

  // status word bit positions
  localparam int unsigned STAT_EV0 = 0;
  localparam int unsigned STAT_EV1 = 8;

  // stream word layout
  localparam int unsigned IN_TUSER_W   = CMD_W;
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned IN_OFF_LSB   = 0;
  localparam int unsigned IN_WDATA_LSB = OFF_W;
  localparam int unsigned IN_REF_BIT   = OFF_W + DATA_W;
  localparam int unsigned OUT_TDATA_W  = 40;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - DATA_W - 1;

  // per-counter control bundle
  typedef struct packed {
    logic tick;      // tick item being processed
    logic ref_tick;  // reference edge during this tick
    logic en;
    logic rld_en;
    logic ref_sel;
  } chan_ctrl_t;

endpackage

FILE: hw/rtl/ddt_chan.sv
// one reloading 32-bit down-counter with its reload register
// depends on ddt_pkg
module ddt_chan #(
  parameter int unsigned DIV_BITS = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ddt_pkg::chan_ctrl_t             ctrl,
  input  logic [DIV_BITS-1:0]             div,
  input  logic [(2**DIV_BITS)-2:0]        prescale,
  input  logic                            wr_reload,
  input  logic                            wr_count,
  input  logic [ddt_pkg::DATA_W-1:0]      wdata,
  output logic [ddt_pkg::DATA_W-1:0]      count,
  output logic [ddt_pkg::DATA_W-1:0]      reload,
  output logic                            event_set
);

  localparam int unsigned PS_W = (2**DIV_BITS) - 1;

  logic [ddt_pkg::DATA_W-1:0] count_r, count_nxt;
  logic [ddt_pkg::DATA_W-1:0] reload_r, reload_nxt;
  logic qual_div;
  logic qual;
  logic hit;
  logic at_zero;

  // low div bits of the prescaler all ones
  always_comb begin
    qual_div = 1'b1;
    for (int i = 0; i < PS_W; i++) begin
      if (i < int'(div)) begin
        qual_div = qual_div & prescale[i];
      end
    end
  end

  assign qual      = ctrl.ref_sel ? ctrl.ref_tick : qual_div;
  assign hit       = ctrl.tick & ctrl.en & qual;
  assign at_zero   = (count_r == '0);
  assign event_set = hit & at_zero;

  always_comb begin
    reload_nxt = wr_reload ? wdata : reload_r;
    priority if (wr_count) begin
      count_nxt = wdata;
    end else if (hit && at_zero) begin
      count_nxt = ctrl.rld_en ? reload_r : '0;
    end else if (hit) begin
      count_nxt = count_r - ddt_pkg::DATA_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      reload_r <= '0;
    end else begin
      count_r  <= count_nxt;
      reload_r <= reload_nxt;
    end
  end

  assign count  = count_r;
  assign reload = reload_r;

endmodule

FILE: hw/rtl/ddt_core.sv
// register file, prescaler and event flags around two counters
// depends on ddt_pkg and ddt_chan
module ddt_core #(
  parameter int unsigned DIV_BITS = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  logic [ddt_pkg::CMD_W-1:0]       cmd,
  input  logic [ddt_pkg::OFF_W-1:0]       off,
  input  logic [ddt_pkg::DATA_W-1:0]      wdata,
  input  logic                            ref_tick,
  output logic [ddt_pkg::DATA_W-1:0]      rd_data,
  output logic                            irq_nxt
);

  localparam int unsigned PS_W = (2**DIV_BITS) - 1;
  localparam int unsigned DIV1_LSB = ddt_pkg::CTRL_DIV0_LSB + DIV_BITS;

  logic [ddt_pkg::DATA_W-1:0] control_r, control_nxt;
  logic [1:0]                 events_r, events_nxt;
  logic [PS_W-1:0]            prescale_r, prescale_nxt;

  logic is_tick, is_wr;
  ddt_pkg::chan_ctrl_t ctrl0, ctrl1;
  logic [ddt_pkg::DATA_W-1:0] count0, count1, reload0, reload1;
  logic set0, set1;
  logic [ddt_pkg::DATA_W-1:0] status_word;

  assign is_tick = fire && (cmd == ddt_pkg::CMD_TICK);
  assign is_wr   = fire && (cmd == ddt_pkg::CMD_WRITE);

  always_comb begin
    ctrl0.tick     = is_tick;
    ctrl0.ref_tick = ref_tick;
    ctrl0.en       = control_r[ddt_pkg::CTRL_EN0];
    ctrl0.rld_en   = control_r[ddt_pkg::CTRL_RLD0];
    ctrl0.ref_sel  = control_r[ddt_pkg::CTRL_REF0];
    ctrl1.tick     = is_tick;
    ctrl1.ref_tick = ref_tick;
    ctrl1.en       = control_r[ddt_pkg::CTRL_EN1];
    ctrl1.rld_en   = control_r[ddt_pkg::CTRL_RLD1];
    ctrl1.ref_sel  = control_r[ddt_pkg::CTRL_REF1];
  end

  ddt_chan #(.DIV_BITS(DIV_BITS)) u_chan0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl0),
    .div       (control_r[ddt_pkg::CTRL_DIV0_LSB +: DIV_BITS]),
    .prescale  (prescale_r),
    .wr_reload (is_wr && (off == ddt_pkg::OFF_RELOAD0)),
    .wr_count  (is_wr && (off == ddt_pkg::OFF_VALUE0)),
    .wdata     (wdata),
    .count     (count0),
    .reload    (reload0),
    .event_set (set0)
  );

  ddt_chan #(.DIV_BITS(DIV_BITS)) u_chan1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl1),
    .div       (control_r[DIV1_LSB +: DIV_BITS]),
    .prescale  (prescale_r),
    .wr_reload (is_wr && (off == ddt_pkg::OFF_RELOAD1)),
    .wr_count  (is_wr && (off == ddt_pkg::OFF_VALUE1)),
    .wdata     (wdata),
    .count     (count1),
    .reload    (reload1),
    .event_set (set1)
  );

  always_comb begin
    control_nxt  = (is_wr && (off == ddt_pkg::OFF_CTRL)) ? wdata : control_r;
    prescale_nxt = is_tick ? (prescale_r + PS_W'(1)) : prescale_r;
    events_nxt   = events_r | {set1, set0};
    if (is_wr && (off == ddt_pkg::OFF_STATUS)) begin
      // writing zero clears, writing one leaves the flag alone
      if (!wdata[ddt_pkg::STAT_EV0]) begin
        events_nxt[0] = 1'b0;
      end
      if (!wdata[ddt_pkg::STAT_EV1]) begin
        events_nxt[1] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r  <= '0;
      events_r   <= '0;
      prescale_r <= '0;
    end else begin
      control_r  <= control_nxt;
      events_r   <= events_nxt;
      prescale_r <= prescale_nxt;
    end
  end

  always_comb begin
    status_word = '0;
    status_word[ddt_pkg::STAT_EV0] = events_r[0];
    status_word[ddt_pkg::STAT_EV1] = events_r[1];
  end

  // read mux; unused offsets read zero
  always_comb begin
    rd_data = '0;
    if (cmd == ddt_pkg::CMD_READ) begin
      unique case (off)
        ddt_pkg::OFF_CTRL:    rd_data = control_r;
        ddt_pkg::OFF_STATUS:  rd_data = status_word;
        ddt_pkg::OFF_RELOAD0: rd_data = reload0;
        ddt_pkg::OFF_VALUE0:  rd_data = count0;
        ddt_pkg::OFF_RELOAD1: rd_data = reload1;
        ddt_pkg::OFF_VALUE1:  rd_data = count1;
        default:              rd_data = '0;
      endcase
    end
  end

  assign irq_nxt = events_nxt[1];

endmodule

FILE: hw/rtl/dual_down_timer_regs_unit.sv
// a word accepted on the input passes the input register and then the result register to the output
// throughput: one word per cycle while out_tready is high; each word is applied to the
// registers in one pass between the input register and the result register
// reset: synchronous active-low rst_n clears both stages' valid flags, the control
// word, event flags, prescaler, reload and count registers
// depends on ddt_pkg and ddt_core
module dual_down_timer_regs_unit #(
  parameter int unsigned DIV_BITS = 3  // divider field width, 1 to 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ddt_pkg::IN_TDATA_W-1:0]     in_tdata,   // reg_offset[2:0], write_data[34:3],
                                                         // ref_tick[35], zero pad [39:36]
  input  logic [ddt_pkg::IN_TUSER_W-1:0]     in_tuser,   // command[1:0]
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ddt_pkg::OUT_TDATA_W-1:0]    out_tdata   // read_data[31:0], irq[32],
                                                         // zero pad [39:33]
);

  // input register stage
  logic                          s1_valid_r, s1_valid_nxt;
  logic [ddt_pkg::CMD_W-1:0]     s1_cmd_r;
  logic [ddt_pkg::OFF_W-1:0]     s1_off_r;
  logic [ddt_pkg::DATA_W-1:0]    s1_wdata_r;
  logic                          s1_ref_r;

  // result register stage
  logic                          out_valid_r, out_valid_nxt;
  logic [ddt_pkg::DATA_W-1:0]    rd_r;
  logic                          irq_r;

  logic in_fire;
  logic s2_load;   // result register free or being drained
  logic s1_fire;   // word in the input register is applied this cycle
  logic [ddt_pkg::DATA_W-1:0] rd_data;
  logic irq_nxt;

  assign s2_load   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s2_load;
  assign in_tready = !s1_valid_r || s2_load;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    priority if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    priority if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= in_tuser;
      s1_off_r   <= in_tdata[ddt_pkg::IN_OFF_LSB +: ddt_pkg::OFF_W];
      s1_wdata_r <= in_tdata[ddt_pkg::IN_WDATA_LSB +: ddt_pkg::DATA_W];
      s1_ref_r   <= in_tdata[ddt_pkg::IN_REF_BIT];
    end
    if (s1_fire) begin
      rd_r  <= rd_data;
      irq_r <= irq_nxt;
    end
  end

  // register file and counters; state commits when the word moves to the result register
  ddt_core #(.DIV_BITS(DIV_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .cmd      (s1_cmd_r),
    .off      (s1_off_r),
    .wdata    (s1_wdata_r),
    .ref_tick (s1_ref_r),
    .rd_data  (rd_data),
    .irq_nxt  (irq_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{ddt_pkg::OUT_PAD_W{1'b0}}, irq_r, rd_r};

endmodule

FILE: hw/rtl/ddt_checker.sv
// port-level checks for the dual down-counter timer, bound to the top level
// depends on ddt_pkg and assert_macros.svh
`include "assert_macros.svh"

module ddt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [ddt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input logic [ddt_pkg::IN_TUSER_W-1:0]     in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [ddt_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  // nothing comes out right after reset
  `ASSERT_CLK_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "out_tvalid high after reset")

  // a stalled result word holds
  `ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // with both stages full, input is taken only when the output drains
  `ASSERT_CLK(a_no_overrun, in_tvalid && in_tready && out_tvalid && !out_tready |=> in_tready == out_tready, "input taken while full")

  // padding bits stay zero
  `ASSERT_CLK(a_pad_zero, out_tvalid |-> out_tdata[ddt_pkg::OUT_TDATA_W-1:ddt_pkg::DATA_W+1] == '0, "nonzero result padding")

endmodule

bind dual_down_timer_regs_unit ddt_checker u_ddt_checker (.*);
